FILE: sv/ftpr_pkg.sv
package ftpr_pkg;

    // Number of counters and the widths that follow from it.
    localparam int DEPTH = 1024;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int N_W   = IDX_W + 1;
    localparam int X_W   = IDX_W + 2;
    localparam int VAL_W = 32;
    localparam int OP_W  = 3;
    localparam int PC_W  = 4;

    typedef logic [VAL_W-1:0] t_val;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_PREFIX = 3'd1,
        OP_RANGE  = 3'd2,
        OP_GET    = 3'd3,
        OP_SET    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        U_DONE = 2'd0,
        U_PSUM = 2'd1,
        U_ADD  = 2'd2
    } t_uop;

    typedef enum logic [1:0] {
        S_A1 = 2'd0,
        S_A  = 2'd1,
        S_B1 = 2'd2,
        S_N  = 2'd3
    } t_start;

    typedef enum logic [1:0] {
        C_LOAD = 2'd0,
        C_ADD  = 2'd1,
        C_SUB  = 2'd2
    } t_comb;

    typedef enum logic {
        D_V       = 1'b0,
        D_V_MINUS = 1'b1
    } t_dsel;

    typedef struct packed {
        t_uop             kind;
        t_start           start;
        t_comb            comb;
        t_dsel            dsel;
        logic             zero_res;
        logic             jmp_nowrap;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        t_val              data;
    } t_ram_wr;

    // Program entry points.
    localparam logic [PC_W-1:0] PC_PREFIX = 4'd0;
    localparam logic [PC_W-1:0] PC_RANGE  = 4'd2;
    localparam logic [PC_W-1:0] PC_GET    = 4'd6;
    localparam logic [PC_W-1:0] PC_SET    = 4'd9;
    localparam logic [PC_W-1:0] PC_ADD    = 4'd13;

    function automatic t_uword mk(t_uop k, t_start s, t_comb c, t_dsel d,
                                  logic z, logic j, logic [PC_W-1:0] t);
        t_uword w;
        w.kind       = k;
        w.start      = s;
        w.comb       = c;
        w.dsel       = d;
        w.zero_res   = z;
        w.jmp_nowrap = j;
        w.target     = t;
        return w;
    endfunction

    // The microprogram. Each prefix walk folds its total into the result,
    // each add walk puts the chosen delta along the update path.
    function automatic t_uword ucode(logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            4'd0:    w = mk(U_PSUM, S_A1, C_LOAD, D_V, 1'b0, 1'b0, '0);
            4'd1:    w = mk(U_DONE, S_A,  C_LOAD, D_V, 1'b0, 1'b0, '0);
            4'd2:    w = mk(U_PSUM, S_B1, C_LOAD, D_V, 1'b0, 1'b0, '0);
            4'd3:    w = mk(U_PSUM, S_A,  C_SUB,  D_V, 1'b0, 1'b1, PC_RANGE + 4'd3);
            4'd4:    w = mk(U_PSUM, S_N,  C_ADD,  D_V, 1'b0, 1'b0, '0);
            4'd5:    w = mk(U_DONE, S_A,  C_LOAD, D_V, 1'b0, 1'b0, '0);
            4'd6:    w = mk(U_PSUM, S_A1, C_LOAD, D_V, 1'b0, 1'b0, '0);
            4'd7:    w = mk(U_PSUM, S_A,  C_SUB,  D_V, 1'b0, 1'b0, '0);
            4'd8:    w = mk(U_DONE, S_A,  C_LOAD, D_V, 1'b0, 1'b0, '0);
            4'd9:    w = mk(U_PSUM, S_A1, C_LOAD, D_V, 1'b0, 1'b0, '0);
            4'd10:   w = mk(U_PSUM, S_A,  C_SUB,  D_V, 1'b0, 1'b0, '0);
            4'd11:   w = mk(U_ADD,  S_A1, C_LOAD, D_V_MINUS, 1'b0, 1'b0, '0);
            4'd12:   w = mk(U_DONE, S_A,  C_LOAD, D_V, 1'b1, 1'b0, '0);
            4'd13:   w = mk(U_ADD,  S_A1, C_LOAD, D_V, 1'b0, 1'b0, '0);
            4'd14:   w = mk(U_DONE, S_A,  C_LOAD, D_V, 1'b1, 1'b0, '0);
            default: w = mk(U_DONE, S_A,  C_LOAD, D_V, 1'b1, 1'b0, '0);
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] entry(t_op op);
        logic [PC_W-1:0] pc;
        unique case (op)
            OP_ADD:    pc = PC_ADD;
            OP_PREFIX: pc = PC_PREFIX;
            OP_RANGE:  pc = PC_RANGE;
            OP_GET:    pc = PC_GET;
            OP_SET:    pc = PC_SET;
            default:   pc = PC_PREFIX;
        endcase
        return pc;
    endfunction

endpackage

FILE: sv/ftpr_ifs.sv
interface ftpr_req_if;
    import ftpr_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [IDX_W-1:0]    first_index;
    logic [IDX_W-1:0]    second_index;
    logic signed [VAL_W-1:0] operand_value;

    modport source (output valid, op, first_index, second_index, operand_value,
                    input ready);
    modport sink   (input valid, op, first_index, second_index, operand_value,
                    output ready);
endinterface

interface ftpr_rsp_if;
    import ftpr_pkg::*;

    logic                valid;
    logic                ready;
    logic signed [VAL_W-1:0] result_value;
    logic                status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

FILE: sv/ftpr_node_ram.sv
module ftpr_node_ram (
    input  logic                       i_clk,
    input  ftpr_pkg::t_ram_wr          i_wr,
    input  logic [ftpr_pkg::IDX_W-1:0] i_raddr,
    output ftpr_pkg::t_val             o_rdata
);
    import ftpr_pkg::*;

    t_val r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: sv/fenwick_tree_point_range_top.sv
// Channel  | Dir | Handshake     | Beat contents
// ---------+-----+---------------+---------------------------------------------------
// i_req    | in  | valid/ready   | op, first_index, second_index, operand_value
// o_rsp    | out | valid/ready   | result_value, status
// i_cfg_*  | in  | write enable  | active_size (11 bits), no read-back
//
// After reset a clearing pass zeroes the 1024 tree nodes, one per cycle; no request
// beat is taken during the pass, though configuration writes are.
// One request is worked on at a time. Its tree walks run one after another, each
// visiting its nodes in turn through the single read port of the node memory.
// A finished result sits in the output register; a new request beat is taken while
// it waits, and the sequencer only stalls when a second result is ready behind it.
module fenwick_tree_point_range_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [ftpr_pkg::N_W-1:0]    i_cfg_wr_data,
    ftpr_req_if.sink                    i_req,
    ftpr_rsp_if.source                  o_rsp
);
    import ftpr_pkg::*;

    // Control states of the sequencer, one-hot.
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic [X_W-1:0]    r_x, n_x;
    t_val              r_acc, n_acc;
    t_val              r_res, n_res;
    t_val              r_delta, n_delta;
    logic              r_rd_v, n_rd_v;
    logic [IDX_W-1:0]  r_wa, n_wa;
    logic [IDX_W-1:0]  r_clr, n_clr;
    logic [IDX_W-1:0]  r_a, n_a;
    logic [IDX_W-1:0]  r_b, n_b;
    t_val              r_v, n_v;
    logic              r_wrap, n_wrap;
    logic              r_st, n_st;
    logic              r_out_valid, n_out_valid;
    t_val              r_out_res, n_out_res;
    logic              r_out_st, n_out_st;
    logic [N_W-1:0]    r_active_size;

    logic [N_W-1:0]    w_n;
    t_uword            w_uw;
    logic [X_W-1:0]    w_low;
    logic [X_W-1:0]    w_start;
    logic              w_walk_done;
    logic              w_flag;
    logic [IDX_W-1:0]  w_raddr;
    t_val              w_rdata;
    t_ram_wr           w_wr;

    // Active size register. A value above the node count acts as the node count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_size <= N_W'(DEPTH);
        end else if (i_cfg_wr_en) begin
            r_active_size <= i_cfg_wr_data;
        end
    end

    assign w_n  = (r_active_size > N_W'(DEPTH)) ? N_W'(DEPTH) : r_active_size;
    assign w_uw = ucode(r_pc);

    // Lowest set bit of the walk index steps to the parent or the next node.
    assign w_low = r_x & (~r_x + X_W'(1));

    always_comb begin
        unique case (w_uw.start)
            S_A1:    w_start = {2'b00, r_a} + X_W'(1);
            S_A:     w_start = {2'b00, r_a};
            S_B1:    w_start = {2'b00, r_b} + X_W'(1);
            S_N:     w_start = {1'b0, w_n};
            default: w_start = {2'b00, r_a};
        endcase
    end

    // A request is flagged when its first index, or for a range its second index, falls outside the active positions.
    assign w_flag = ({1'b0, i_req.first_index} >= w_n) ||
                    ((t_op'(i_req.op) == OP_RANGE) && ({1'b0, i_req.second_index} >= w_n));

    // Node x lives at memory address x-1; the walk never reads node zero.
    assign w_raddr = IDX_W'(r_x - X_W'(1));

    ftpr_node_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_x         = r_x;
        n_acc       = r_acc;
        n_res       = r_res;
        n_delta     = r_delta;
        n_rd_v      = 1'b0;
        n_wa        = r_wa;
        n_clr       = r_clr;
        n_a         = r_a;
        n_b         = r_b;
        n_v         = r_v;
        n_wrap      = r_wrap;
        n_st        = r_st;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_res   = r_out_res;
        n_out_st    = r_out_st;
        w_wr.we     = 1'b0;
        w_wr.addr   = r_wa;
        w_wr.data   = w_rdata + r_delta;
        w_walk_done = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                w_wr.we   = 1'b1;
                w_wr.addr = r_clr;
                w_wr.data = '0;
                n_clr     = r_clr + IDX_W'(1);
                if (r_clr == IDX_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (i_req.valid) begin
                    n_a    = i_req.first_index;
                    n_b    = i_req.second_index;
                    n_v    = t_val'(i_req.operand_value);
                    n_wrap = i_req.first_index > i_req.second_index;
                    n_res  = '0;
                    n_pc   = entry(t_op'(i_req.op));
                    // Unknown operations finish at once with a zero result.
                    if (i_req.op > OP_W'(OP_SET)) begin
                        n_st    = 1'b0;
                        n_state = ST_DONE;
                    end else if (w_flag) begin
                        n_st    = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_st    = 1'b0;
                        n_state = ST_LOAD;
                    end
                end
            end

            ST_LOAD: begin
                if (w_uw.kind == U_DONE) begin
                    if (w_uw.zero_res) begin
                        n_res = '0;
                    end
                    n_state = ST_DONE;
                end else begin
                    n_x   = w_start;
                    n_acc = '0;
                    if (w_uw.dsel == D_V_MINUS) begin
                        n_delta = r_v - r_res;
                    end else begin
                        n_delta = r_v;
                    end
                    n_state = ST_WALK;
                end
            end

            ST_WALK: begin
                if (w_uw.kind == U_ADD) begin
                    // Read one node per cycle going up; write it back in the next cycle.
                    if (r_x <= {1'b0, w_n}) begin
                        n_rd_v = 1'b1;
                        n_wa   = w_raddr;
                        n_x    = r_x + w_low;
                    end
                    w_wr.we     = r_rd_v;
                    w_walk_done = (r_x > {1'b0, w_n}) && !r_rd_v;
                end else begin
                    // Read one node per cycle going down; add it into the sum in the next cycle.
                    if (r_x != '0) begin
                        n_rd_v = 1'b1;
                        n_x    = r_x - w_low;
                    end
                    if (r_rd_v) begin
                        n_acc = r_acc + w_rdata;
                    end
                    w_walk_done = (r_x == '0) && !r_rd_v;
                end

                if (w_walk_done) begin
                    if (w_uw.kind == U_PSUM) begin
                        unique case (w_uw.comb)
                            C_LOAD:  n_res = r_acc;
                            C_ADD:   n_res = r_res + r_acc;
                            C_SUB:   n_res = r_res - r_acc;
                            default: n_res = r_acc;
                        endcase
                    end
                    if (w_uw.jmp_nowrap && !r_wrap) begin
                        n_pc = w_uw.target;
                    end else begin
                        n_pc = r_pc + PC_W'(1);
                    end
                    n_state = ST_LOAD;
                end
            end

            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_res;
                    n_out_st    = r_st;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_pc        <= '0;
            r_rd_v      <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_rd_v      <= n_rd_v;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_acc     <= n_acc;
        r_res     <= n_res;
        r_delta   <= n_delta;
        r_wa      <= n_wa;
        r_a       <= n_a;
        r_b       <= n_b;
        r_v       <= n_v;
        r_wrap    <= n_wrap;
        r_st      <= n_st;
        r_out_res <= n_out_res;
        r_out_st  <= n_out_st;
    end

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_res;
    assign o_rsp.status       = r_out_st;

    // Once a request beat is taken the sequencer is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while a request is in progress");

    // No result leaves while the node memory is being cleared.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_rsp.valid)
        else $error("result beat during the clearing pass");

    // A flagged result carries a zero value.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status) |-> (o_rsp.result_value == '0))
        else $error("flagged result with a nonzero value");

    // The node memory is written only by the clearing pass or an add walk.
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.we |-> ((r_state == ST_CLEAR) ||
                     ((r_state == ST_WALK) && (w_uw.kind == U_ADD))))
        else $error("node memory written outside an update");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ftpr_pkg::*;

    // Codes 5 to 7 of the op field are not assigned; the block must answer them with a
    // zero result and a clear status, and leave the tree alone.
    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    localparam logic [N_W-1:0] SIZE_NONE     = 11'd0;
    localparam logic [N_W-1:0] SIZE_ONE      = 11'd1;
    localparam logic [N_W-1:0] SIZE_FULL     = 11'd1024;
    localparam logic [N_W-1:0] SIZE_OVERSIZE = 11'd2047;

    // The longest quiet stretch of a correct run is the clearing pass after reset
    // or the deliberate receiver hold-off; this is several times either.
    localparam int STALL_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        t_val value;
        logic status;
    } t_tree_result;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_cfg_wr_en;
    logic [N_W-1:0] i_cfg_wr_data;

    ftpr_req_if req_bus ();
    ftpr_rsp_if rsp_bus ();

    fenwick_tree_point_range_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_bus),
        .o_rsp         (rsp_bus)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Our own copy of the tree and of the size register, updated in step with every
    // accepted request beat and every register write.
    t_val           tree_mirror [1:DEPTH];
    logic [N_W-1:0] mirror_size;

    // Results still owed by the block, oldest first.
    t_tree_result   awaited_results [$];
    int             mismatch_count = 0;

    // Idling controls shared between the stimulus and the result sink.
    bit             src_idle_on = 1'b1;
    bit             snk_idle_on = 1'b1;
    int             hold_off_cycles = 0;

    function automatic int unsigned effective_size();
        return (mirror_size > DEPTH) ? DEPTH : int'(mirror_size);
    endfunction

    // Total of positions 0..count-1. The walk is capped at the full depth only, so
    // nodes written under a larger size still count after the size shrinks.
    function automatic t_val mirror_prefix(int unsigned count);
        int unsigned x;
        t_val        acc;
        acc = '0;
        x   = (count > DEPTH) ? DEPTH : count;
        while (x > 0) begin
            acc = acc + tree_mirror[x];
            x   = x - (x & (~x + 1));
        end
        return acc;
    endfunction

    function automatic void mirror_add(int unsigned pos, t_val delta, int unsigned n);
        int unsigned x;
        x = pos + 1;
        while (x <= n) begin
            tree_mirror[x] = tree_mirror[x] + delta;
            x = x + (x & (~x + 1));
        end
    endfunction

    function automatic t_val mirror_point(int unsigned pos);
        return mirror_prefix(pos + 1) - mirror_prefix(pos);
    endfunction

    // Expected answer to one request, applying its update to the mirror on the way.
    function automatic t_tree_result fenwick_predict(logic [OP_W-1:0] op,
                                                     logic [IDX_W-1:0] first_idx,
                                                     logic [IDX_W-1:0] second_idx,
                                                     t_val operand);
        t_tree_result r;
        int unsigned  n;
        int unsigned  a;
        int unsigned  b;
        r.value  = '0;
        r.status = 1'b0;
        n = effective_size();
        a = 32'(first_idx);
        b = 32'(second_idx);
        if (!(op inside {OP_ADD, OP_PREFIX, OP_RANGE, OP_GET, OP_SET}))
            return r;
        if (a >= n || (op == OP_RANGE && b >= n)) begin
            r.status = 1'b1;
            return r;
        end
        case (op)
            OP_ADD:    mirror_add(a, operand, n);
            OP_PREFIX: r.value = mirror_prefix(a + 1);
            OP_RANGE: begin
                // A start past the end wraps: head of the tree plus its tail.
                if (a <= b)
                    r.value = mirror_prefix(b + 1) - mirror_prefix(a);
                else
                    r.value = mirror_prefix(b + 1) + (mirror_prefix(n) - mirror_prefix(a));
            end
            OP_GET:    r.value = mirror_point(a);
            OP_SET:    mirror_add(a, operand - mirror_point(a), n);
            default:   ;
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(string what, t_val want, t_val got);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t: %s: expected %h, got %h", $time, what, want, got);
        mismatch_count++;
    endtask

    // Offers one request beat and returns at the edge that takes it. Valid is left
    // high so that a back-to-back beat needs no second assignment in one step.
    task automatic send_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] first_idx,
                                logic [IDX_W-1:0] second_idx, t_val operand);
        int gap;
        gap = src_idle_on ? $urandom_range(17, 0) : 0;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.op            <= op;
        req_bus.first_index   <= first_idx;
        req_bus.second_index  <= second_idx;
        req_bus.operand_value <= operand;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        awaited_results.push_back(fenwick_predict(op, first_idx, second_idx, operand));
    endtask

    // Stops offering beats and waits until the block has answered everything.
    // Every request yields a result, so an empty queue means the block is idle;
    // the extra wait at the end only lets the output side settle.
    task automatic wait_for_results();
        req_bus.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_active_size(logic [N_W-1:0] size);
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= size;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        mirror_size    = size;
    endtask

    task automatic send_random_item();
        int unsigned      n;
        int unsigned      pick;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        t_val             v;
        n    = effective_size();
        pick = $urandom_range(99, 0);
        if (pick < 30)
            op = OP_ADD;
        else if (pick < 45)
            op = OP_SET;
        else if (pick < 60)
            op = OP_PREFIX;
        else if (pick < 80)
            op = OP_RANGE;
        else if (pick < 95)
            op = OP_GET;
        else
            op = OP_W'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
        // Mostly indices inside the active range; the rest spans the whole field
        // and so can also land out of range whenever the size is below the depth.
        if (n != 0 && $urandom_range(9, 0) != 0) begin
            a = IDX_W'($urandom_range(n - 1, 0));
            b = IDX_W'($urandom_range(n - 1, 0));
        end else begin
            a = IDX_W'($urandom);
            b = IDX_W'($urandom);
        end
        case ($urandom_range(3, 0))
            0: v = t_val'($urandom_range(200, 0)) - 32'd100;
            1: begin
                case ($urandom_range(3, 0))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        send_request(op, a, b, v);
    endtask

    // Directed opening on an empty tree of full size: extremes of every field,
    // every operation, a wrapped range and the unused op codes.
    task automatic test_directed_ops();
        send_request(OP_ADD,    10'd0,    10'd0,    32'h7FFF_FFFF);
        send_request(OP_ADD,    10'd1023, 10'd0,    32'h8000_0000);
        send_request(OP_ADD,    10'd512,  10'd0,    32'hFFFF_FFFF);
        send_request(OP_PREFIX, 10'd0,    10'd0,    32'h0);
        send_request(OP_PREFIX, 10'd1023, 10'd1023, 32'h0);
        send_request(OP_RANGE,  10'd0,    10'd1023, 32'h0);
        send_request(OP_RANGE,  10'd1023, 10'd0,    32'h0);
        send_request(OP_RANGE,  10'd512,  10'd512,  32'h0);
        send_request(OP_GET,    10'd1023, 10'd0,    32'h0);
        send_request(OP_SET,    10'd0,    10'd0,    32'h0);
        send_request(OP_SET,    10'd700,  10'd0,    32'h5A5A_A5A5);
        send_request(OP_GET,    10'd700,  10'd0,    32'h0);
        send_request(OP_RSVD_FIRST, 10'd0, 10'd0,   32'h0);
        send_request(OP_RSVD_LAST,  '1,    '1,      '1);
    endtask

    // Size register corners: zero flags every known operation, one leaves a single position,
    // and anything above the depth behaves as the depth. The tree is never rebuilt,
    // so the nodes written above carry over into each of these settings.
    task automatic test_size_corners();
        write_active_size(SIZE_NONE);
        send_request(OP_ADD,   10'd0, 10'd0, 32'h1234_5678);
        send_request(OP_RANGE, 10'd0, 10'd0, 32'h0);

        write_active_size(SIZE_ONE);
        send_request(OP_ADD,   10'd0, 10'd0, 32'd5);
        send_request(OP_RANGE, 10'd0, 10'd0, 32'h0);
        send_request(OP_GET,   10'd0, 10'd0, 32'h0);
        send_request(OP_ADD,   10'd1, 10'd0, 32'd9);
        send_request(OP_RANGE, 10'd0, 10'd1, 32'h0);

        write_active_size(SIZE_OVERSIZE);
        send_request(OP_RANGE,  10'd1023, 10'd3,    32'h0);
        send_request(OP_PREFIX, 10'd1023, 10'd0,    32'h0);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // beats back to back, so the block fills and stalls its input. Then the sender
    // pauses until every result is in before it carries on.
    task automatic test_backpressure();
        write_active_size(SIZE_FULL);
        src_idle_on     = 1'b0;
        snk_idle_on     = 1'b0;
        hold_off_cycles = HOLD_CYCLES;
        repeat (30) send_random_item();
        wait_for_results();
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        repeat (10) send_random_item();
    endtask

    // Phases of random requests, each under its own size and idling mix. Two of
    // the phases run with no idling on either side.
    task automatic test_random_phases();
        logic [N_W-1:0] size;
        int             items;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0:       size = SIZE_FULL;
                1:       size = SIZE_OVERSIZE;
                2:       size = SIZE_ONE;
                3:       size = 11'd2;
                4:       size = SIZE_NONE;
                5:       size = 11'd1000;
                6:       size = 11'd37;
                9:       size = SIZE_FULL;
                default: size = N_W'($urandom_range(SIZE_FULL, SIZE_ONE));
            endcase
            write_active_size(size);
            if (ph == 3 || ph == 7) begin
                src_idle_on = 1'b0;
                snk_idle_on = 1'b0;
            end else begin
                src_idle_on = 1'($urandom_range(1, 0));
                snk_idle_on = 1'($urandom_range(1, 0));
            end
            // With no active positions every request of a known operation is only
            // flagged, so that phase stays short.
            items = (size == SIZE_NONE) ? 8 : 70;
            repeat (items) send_random_item();
        end
    endtask

    initial begin : run_tests
        for (int i = 1; i <= DEPTH; i++)
            tree_mirror[i] = '0;
        mirror_size = SIZE_FULL;

        i_rst_n               <= 1'b0;
        i_cfg_wr_en           <= 1'b0;
        i_cfg_wr_data         <= '0;
        req_bus.valid         <= 1'b0;
        req_bus.op            <= '0;
        req_bus.first_index   <= '0;
        req_bus.second_index  <= '0;
        req_bus.operand_value <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The clearing pass holds off the first request beat; send_request simply waits on ready through it.
        test_directed_ops();
        test_size_corners();
        test_backpressure();
        test_random_phases();

        req_bus.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result side: draws a stall for every beat when idling is on, takes the beat, and
    // compares it with the oldest prediction. Outputs are read right after the edge, so they
    // still hold the values that the edge itself saw.
    initial begin : result_sink
        int           stall;
        t_tree_result want;
        rsp_bus.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_off_cycles > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end else begin
                stall = snk_idle_on ? $urandom_range(17, 0) : 0;
                if (stall > 0) begin
                    rsp_bus.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_bus.valid !== 1'b1);

            if (awaited_results.size() == 0) begin
                flag_mismatch("result beat with no request outstanding", '0,
                              rsp_bus.result_value);
            end else begin
                want = awaited_results.pop_front();
                if (rsp_bus.result_value !== want.value)
                    flag_mismatch("result_value", want.value, rsp_bus.result_value);
                if (rsp_bus.status !== want.status)
                    flag_mismatch("status", t_val'(want.status), t_val'(rsp_bus.status));
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule
